// ----- sv/stf_pkg.sv -----
// ----------------------------------------------------------------------------
// stf_pkg
// shared types and constants of the shard term fencing table
// ----------------------------------------------------------------------------
package stf_pkg;

  localparam int SHARD_COUNT = 1024;
  localparam int SHARD_W     = 10;
  localparam int TERM_W      = 64;
  localparam int IDX_W       = $clog2(SHARD_COUNT);
  // wide enough to hold the largest table size
  localparam int CMP_W       = 17;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_CHECK  = 1'b1;

  localparam logic [1:0] VERDICT_ACCEPT      = 2'd0;
  localparam logic [1:0] VERDICT_UNKNOWN     = 2'd1;
  localparam logic [1:0] VERDICT_NOT_PRIMARY = 2'd2;
  localparam logic [1:0] VERDICT_STALE       = 2'd3;

  typedef struct packed {
    logic              is_check;
    logic              in_table;
    logic [IDX_W-1:0]  idx;
    logic              role;
    logic [TERM_W-1:0] term;
  } stf_item_t;

  typedef struct packed {
    logic              known;
    logic              role;
    logic [TERM_W-1:0] term;
  } stf_entry_t;

  typedef struct packed {
    logic      push;
    stf_item_t item;
  } stf_push_t;

endpackage

// ----- sv/shard_term_fencing_table.sv -----
// ----------------------------------------------------------------------------
// shard_term_fencing_table
// per-shard fencing token table with role reports and write admission checks
// ----------------------------------------------------------------------------
// result: registered once the table entry of a transaction is read and evaluated
// throughput: the engine takes a new transaction only after the read then write of the
//   single-port table memory for the previous one is done
// reset: synchronous; a clearing pass over all SHARD_COUNT entries (1024) follows,
//   with in_stall high until it is done
module shard_term_fencing_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [stf_pkg::SHARD_W-1:0] in_shard_id,
  input  logic                        in_report_primary,
  input  logic [stf_pkg::TERM_W-1:0]  in_term,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_report_accepted,
  output logic [1:0]                  out_verdict,
  output logic                        out_entry_known,
  output logic                        out_entry_primary,
  output logic [stf_pkg::TERM_W-1:0]  out_entry_term
);
  import stf_pkg::*;

  stf_push_t q_push;
  stf_item_t q_head;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  logic      clearing;

  stf_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_shard_id       (in_shard_id),
    .in_report_primary (in_report_primary),
    .in_term           (in_term),
    .q_full            (q_full),
    .clearing          (clearing),
    .q_push            (q_push)
  );

  stf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (q_head)
  );

  stf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .clearing            (clearing),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_report_accepted (out_report_accepted),
    .out_verdict         (out_verdict),
    .out_entry_known     (out_entry_known),
    .out_entry_primary   (out_entry_primary),
    .out_entry_term      (out_entry_term)
  );

endmodule

// ----- sv/stf_front.sv -----
// ----------------------------------------------------------------------------
// stf_front
// accepts transactions and classifies them for the table engine
// ----------------------------------------------------------------------------
module stf_front (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic [stf_pkg::SHARD_W-1:0] in_shard_id,
  input  logic                       in_report_primary,
  input  logic [stf_pkg::TERM_W-1:0] in_term,
  input  logic                       q_full,
  input  logic                       clearing,
  output stf_pkg::stf_push_t         q_push
);
  import stf_pkg::*;

  logic in_table;

  assign in_table = CMP_W'(in_shard_id) < CMP_W'(SHARD_COUNT);
  assign in_stall = q_full | clearing;

  always_comb begin
    q_push.push          = in_valid & ~in_stall;
    q_push.item.is_check = (in_req_type == REQ_CHECK);
    q_push.item.in_table = in_table;
    q_push.item.idx      = IDX_W'(in_shard_id);
    q_push.item.role     = in_report_primary;
    q_push.item.term     = in_term;
  end

endmodule

// ----- sv/stf_queue.sv -----
// ----------------------------------------------------------------------------
// stf_queue
// short queue between the front and the table engine
// ----------------------------------------------------------------------------
module stf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  stf_pkg::stf_push_t  q_push,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output stf_pkg::stf_item_t  head
);
  import stf_pkg::*;

  stf_item_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_pop;

  assign full   = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty  = (count_r == '0);
  assign head   = slot_r[rd_ptr_r];
  assign do_pop = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push.push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_push.push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slot_r[wr_ptr_r] <= q_push.item;
    end
  end

endmodule

// ----- sv/stf_back.sv -----
// ----------------------------------------------------------------------------
// stf_back
// table engine: clearing pass, read-modify-write of one entry, result register
// ----------------------------------------------------------------------------
module stf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  stf_pkg::stf_item_t         q_head,
  output logic                       q_pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_report_accepted,
  output logic [1:0]                 out_verdict,
  output logic                       out_entry_known,
  output logic                       out_entry_primary,
  output logic [stf_pkg::TERM_W-1:0] out_entry_term
);
  import stf_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EVAL  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  stf_item_t        work_r;
  stf_entry_t       rdata_r;
  stf_entry_t       mem [SHARD_COUNT];

  logic             start;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  stf_entry_t       mem_wdata;

  logic             known;
  logic             accepted;
  logic [1:0]       verdict;
  stf_entry_t       new_entry;
  stf_entry_t       snap;

  logic             out_valid_r, out_valid_nxt;
  logic             out_acc_r;
  logic [1:0]       out_verdict_r;
  stf_entry_t       out_snap_r;

  assign clearing = (state_r == S_CLEAR);
  assign start    = (state_r == S_IDLE) && !q_empty && (!out_valid_r || !out_stall);
  assign q_pop    = start;

  // evaluation against the entry read out of the table
  always_comb begin
    known     = work_r.in_table & rdata_r.known;
    accepted  = 1'b0;
    verdict   = VERDICT_ACCEPT;
    new_entry = rdata_r;
    if (work_r.is_check) begin
      if (!known) begin
        verdict = VERDICT_UNKNOWN;
      end else if (!rdata_r.role) begin
        verdict = VERDICT_NOT_PRIMARY;
      end else if (rdata_r.term != work_r.term) begin
        verdict = VERDICT_STALE;
      end
    end else if (work_r.in_table) begin
      accepted = !rdata_r.known || (work_r.term > rdata_r.term) ||
                 ((work_r.term == rdata_r.term) && (work_r.role == rdata_r.role));
    end
    if (accepted) begin
      new_entry.known = 1'b1;
      new_entry.role  = work_r.role;
      new_entry.term  = work_r.term;
    end
    if (accepted || known) begin
      snap = new_entry;
    end else begin
      snap = '0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    mem_we      = 1'b0;
    mem_waddr   = work_r.idx;
    mem_wdata   = new_entry;
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_W'(SHARD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        mem_we    = accepted;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_EVAL) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (start) begin
      rdata_r <= mem[q_head.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= q_head;
    end
    if (state_r == S_EVAL) begin
      out_acc_r     <= accepted;
      out_verdict_r <= verdict;
      out_snap_r    <= snap;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_report_accepted = out_acc_r;
  assign out_verdict         = out_verdict_r;
  assign out_entry_known     = out_snap_r.known;
  assign out_entry_primary   = out_snap_r.role;
  assign out_entry_term      = out_snap_r.term;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the shard term fencing table: role reports and
// write admission checks go in through the valid/stall input channel, and
// every result is compared field by field against an in-bench copy of the
// per-shard table, with random idle gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stf_pkg::*;

  typedef struct packed {
    logic              accepted;
    logic [1:0]        verdict;
    logic              known;
    logic              primary;
    logic [TERM_W-1:0] term;
  } fence_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_req_type;
  logic [SHARD_W-1:0]  in_shard_id;
  logic                in_report_primary;
  logic [TERM_W-1:0]   in_term;
  logic                out_valid;
  logic                out_stall;
  logic                out_report_accepted;
  logic [1:0]          out_verdict;
  logic                out_entry_known;
  logic                out_entry_primary;
  logic [TERM_W-1:0]   out_entry_term;

  bit                  known_tab [SHARD_COUNT];
  bit                  role_tab [SHARD_COUNT];
  logic [TERM_W-1:0]   term_tab [SHARD_COUNT];
  fence_result_t       pending_results [$];
  int unsigned         mismatches;
  int unsigned         results_seen;
  bit                  tx_idle;
  bit                  rx_idle;

  shard_term_fencing_table u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_shard_id         (in_shard_id),
    .in_report_primary   (in_report_primary),
    .in_term             (in_term),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_report_accepted (out_report_accepted),
    .out_verdict         (out_verdict),
    .out_entry_known     (out_entry_known),
    .out_entry_primary   (out_entry_primary),
    .out_entry_term      (out_entry_term)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // table update and snapshot for one accepted transaction
  function automatic fence_result_t predict_fence(logic rtype, logic [SHARD_W-1:0] sid,
                                                  logic rprim, logic [TERM_W-1:0] t);
    fence_result_t r;
    bit            in_tab;
    r = '0;
    in_tab = (int'(sid) < SHARD_COUNT);
    if (rtype == REQ_CHECK) begin
      if (!in_tab || !known_tab[sid]) r.verdict = VERDICT_UNKNOWN;
      else if (!role_tab[sid]) r.verdict = VERDICT_NOT_PRIMARY;
      else if (term_tab[sid] != t) r.verdict = VERDICT_STALE;
      else r.verdict = VERDICT_ACCEPT;
    end else if (in_tab) begin
      if (!known_tab[sid] || t > term_tab[sid] ||
          (t == term_tab[sid] && role_tab[sid] == rprim)) begin
        known_tab[sid] = 1'b1;
        role_tab[sid]  = rprim;
        term_tab[sid]  = t;
        r.accepted     = 1'b1;
      end
    end
    if (in_tab && known_tab[sid]) begin
      r.known   = 1'b1;
      r.primary = role_tab[sid];
      r.term    = term_tab[sid];
    end
    return r;
  endfunction

  function automatic bit field_ok(string fname, logic [TERM_W-1:0] want,
                                  logic [TERM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // called and returns at a falling edge
  task automatic send_item(logic rtype, logic [SHARD_W-1:0] sid, logic rprim,
                           logic [TERM_W-1:0] t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= rtype;
    in_shard_id       <= sid;
    in_report_primary <= rprim;
    in_term           <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(predict_fence(rtype, sid, rprim, t));
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    fence_result_t want;
    bit            ok;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual verdict %h term %h",
                 $time, out_verdict, out_entry_term);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        ok = field_ok("report_accepted", TERM_W'(want.accepted),
                      TERM_W'(out_report_accepted));
        ok = field_ok("verdict", TERM_W'(want.verdict), TERM_W'(out_verdict)) && ok;
        ok = field_ok("entry_known", TERM_W'(want.known), TERM_W'(out_entry_known)) && ok;
        ok = field_ok("entry_primary", TERM_W'(want.primary),
                      TERM_W'(out_entry_primary)) && ok;
        ok = field_ok("entry_term", want.term, out_entry_term) && ok;
        if (!ok) mismatches++;
      end
    end
  end

  // receiver stalls, redrawn after every accepted result
  initial begin : result_stall
    int unsigned seen;
    int unsigned stall_left;
    seen = 0;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (results_seen != seen) begin
        seen = results_seen;
        stall_left = rx_idle ? $urandom_range(0, 14) : 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_unknown_shard();
    send_item(REQ_CHECK, '0, 1'b1, '0);
    send_item(REQ_CHECK, '1, 1'b0, '1);
    send_item(REQ_REPORT, 10'd512, 1'b0, 64'd3);
    send_item(REQ_CHECK, 10'd513, 1'b1, 64'd3);
  endtask

  task automatic test_term_extremes();
    send_item(REQ_REPORT, '1, 1'b1, '1);
    send_item(REQ_CHECK, '1, 1'b0, '1);
    send_item(REQ_CHECK, '1, 1'b1, '0);
    send_item(REQ_CHECK, '1, 1'b1, {TERM_W{1'b1}} - 1'b1);
    send_item(REQ_REPORT, '0, 1'b1, '0);
    send_item(REQ_CHECK, '0, 1'b0, '0);
  endtask

  task automatic test_report_rules();
    send_item(REQ_REPORT, 10'd100, 1'b0, 64'd5);
    send_item(REQ_CHECK, 10'd100, 1'b1, 64'd6);
    send_item(REQ_REPORT, 10'd100, 1'b1, 64'd5);
    send_item(REQ_REPORT, 10'd100, 1'b0, 64'd5);
    send_item(REQ_REPORT, 10'd100, 1'b1, 64'd4);
    send_item(REQ_REPORT, 10'd100, 1'b1, 64'd6);
    send_item(REQ_CHECK, 10'd100, 1'b0, 64'd6);
    send_item(REQ_CHECK, 10'd100, 1'b0, 64'd7);
  endtask

  task automatic test_back_to_back();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_item(REQ_REPORT, 10'h155, 1'b1, 64'd1);
    send_item(REQ_CHECK, 10'h155, 1'b0, 64'd1);
    send_item(REQ_REPORT, 10'h155, 1'b1, 64'd2);
    send_item(REQ_CHECK, 10'h155, 1'b0, 64'd1);
    send_item(REQ_REPORT, 10'h2aa, 1'b0, 64'hAAAA_5555_AAAA_5555);
    send_item(REQ_CHECK, 10'h2aa, 1'b1, 64'hAAAA_5555_AAAA_5555);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // mostly follow-on terms on a few busy shards, plus noise over the table
  task automatic test_random(int unsigned count);
    logic [SHARD_W-1:0] busy [16];
    logic [SHARD_W-1:0] sid;
    logic [TERM_W-1:0]  t;
    logic               rtype;
    logic               rprim;
    int unsigned        pick;
    foreach (busy[i]) busy[i] = SHARD_W'($urandom_range(0, SHARD_COUNT - 1));
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        tx_idle = 1'($urandom_range(0, 1));
        rx_idle = 1'($urandom_range(0, 1));
      end
      sid = ($urandom_range(0, 9) < 7) ? busy[$urandom_range(0, 15)]
                                        : SHARD_W'($urandom);
      rtype = 1'($urandom_range(0, 1));
      rprim = ($urandom_range(0, 9) < 7);
      pick = $urandom_range(0, 99);
      if (known_tab[sid]) begin
        if (pick < 40) t = term_tab[sid];
        else if (pick < 60) t = term_tab[sid] + 1'b1;
        else if (pick < 70) t = term_tab[sid] - 1'b1;
        else if (pick < 80) t = term_tab[sid] + TERM_W'($urandom_range(2, 50));
        else if (pick < 95) t = {$urandom, $urandom};
        else t = pick[0] ? '1 : '0;
      end else begin
        t = (pick < 25) ? {$urandom, $urandom} : TERM_W'($urandom_range(0, 100));
      end
      send_item(rtype, sid, rprim, t);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_req_type       = REQ_REPORT;
    in_shard_id       = '0;
    in_report_primary = 1'b0;
    in_term           = '0;
    tx_idle           = 1'b1;
    rx_idle           = 1'b1;
    mismatches        = 0;
    results_seen      = 0;
    foreach (term_tab[i]) term_tab[i] = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_unknown_shard();
    test_term_extremes();
    test_report_rules();
    test_back_to_back();
    test_random(1700);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
